// File: rtl/core/nfci_pkg.sv
`default_nettype none
package nfci_pkg;

  localparam int unsigned STAGE_W = 3;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CA_W    = 15;
  localparam int unsigned BUSY_W  = 24;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [CMD_W-1:0] CMD_NONE         = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROGRAM      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SECTOR_ERASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CHIP_ERASE   = 2'd3;

  localparam logic [STAGE_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STAGE_W-1:0] ST_AA1   = 3'd1;
  localparam logic [STAGE_W-1:0] ST_55A   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_PROG  = 3'd3;
  localparam logic [STAGE_W-1:0] ST_ERASE = 3'd4;
  localparam logic [STAGE_W-1:0] ST_AA2   = 3'd5;
  localparam logic [STAGE_W-1:0] ST_55B   = 3'd6;

  localparam logic [CA_W-1:0] UNLOCK_ADDR1 = 15'h5555;
  localparam logic [CA_W-1:0] UNLOCK_ADDR2 = 15'h2aaa;

  localparam logic [7:0] DAT_UNLOCK1 = 8'haa;
  localparam logic [7:0] DAT_UNLOCK2 = 8'h55;
  localparam logic [7:0] DAT_PROGRAM = 8'ha0;
  localparam logic [7:0] DAT_ERASE   = 8'h80;
  localparam logic [7:0] DAT_SECTOR  = 8'h30;
  localparam logic [7:0] DAT_CHIP    = 8'h10;

  localparam logic [1:0] REG_PROGRAM_TICKS = 2'd0;
  localparam logic [1:0] REG_SECTOR_TICKS  = 2'd1;
  localparam logic [1:0] REG_CHIP_TICKS    = 2'd2;

  typedef struct packed {
    logic [STAGE_W-1:0] next_stage;
    logic [CMD_W-1:0]   cmd;
  } seq_out_t;

endpackage
`default_nettype wire

// File: rtl/core/nfci_seq_decode.sv
`default_nettype none
module nfci_seq_decode
  import nfci_pkg::*;
(
  input  wire logic [STAGE_W-1:0] stage,
  input  wire logic [CA_W-1:0]    cmd_addr,
  input  wire logic [7:0]         wdata,
  output seq_out_t                res
);

  logic at1;
  logic at2;

  assign at1 = (cmd_addr == UNLOCK_ADDR1);
  assign at2 = (cmd_addr == UNLOCK_ADDR2);

  always_comb begin
    res.next_stage = ST_IDLE;
    res.cmd        = CMD_NONE;
    unique case (stage)
      ST_IDLE: begin
        if (at1 && wdata == DAT_UNLOCK1) res.next_stage = ST_AA1;
      end
      ST_AA1: begin
        if (at2 && wdata == DAT_UNLOCK2) res.next_stage = ST_55A;
      end
      ST_55A: begin
        if (at1 && wdata == DAT_PROGRAM) res.next_stage = ST_PROG;
        else if (at1 && wdata == DAT_ERASE) res.next_stage = ST_ERASE;
      end
      ST_PROG: begin
        res.cmd = CMD_PROGRAM;
      end
      ST_ERASE: begin
        if (at1 && wdata == DAT_UNLOCK1) res.next_stage = ST_AA2;
      end
      ST_AA2: begin
        if (at2 && wdata == DAT_UNLOCK2) res.next_stage = ST_55B;
      end
      ST_55B: begin
        // sector erase takes any address, chip erase needs the unlock address
        if (wdata == DAT_SECTOR) res.cmd = CMD_SECTOR_ERASE;
        else if (at1 && wdata == DAT_CHIP) res.cmd = CMD_CHIP_ERASE;
      end
      default: begin
        res.next_stage = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/nor_flash_command_interface.sv
`default_nettype none
// Command side of a parallel NOR flash. Each input transaction is a bus read,
// a bus write or a time tick (in_tuser); every one yields exactly one result
// transaction. One transaction is taken per clock cycle when the output side
// keeps up; a result is presented after passing an input register and a result
// register, and the command tracker and busy countdown are updated in the
// single step between them. Unlock/program/erase sequences are reported on
// out_tuser; while busy, reads return status (bit 7 data polling, bit 6
// toggle). The user must write the duration registers through cfg_* only while
// no transaction is in flight; the block itself does not enforce this.
module nor_flash_command_interface
  import nfci_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 19
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic                                     in_tvalid,
  output      logic                                     in_tready,
  // offset, write_data, array_byte (from bit 0 up), zero padded
  input  wire logic [((ADDR_BITS+16+7)/8)*8-1:0]        in_tdata,
  // opcode
  input  wire logic [OP_W-1:0]                          in_tuser,

  output      logic                                     out_tvalid,
  input  wire logic                                     out_tready,
  // read_data, command_address, command_data, busy_res (from bit 0 up), zero padded
  output      logic [((ADDR_BITS+17+7)/8)*8-1:0]        out_tdata,
  // command_issued
  output      logic [CMD_W-1:0]                         out_tuser,

  input  wire logic                                     cfg_wr_en,
  input  wire logic [1:0]                               cfg_index,
  input  wire logic [BUSY_W-1:0]                        cfg_wdata
);

  localparam int unsigned OUT_W = ((ADDR_BITS + 17 + 7) / 8) * 8;

  logic [15:0]         prog_ticks_r;
  logic [BUSY_W-1:0]   sect_ticks_r;
  logic [BUSY_W-1:0]   chip_ticks_r;

  logic                s1_valid_r;
  logic [OP_W-1:0]     s1_op_r;
  logic [ADDR_BITS-1:0] s1_addr_r;
  logic [7:0]          s1_wdata_r;
  logic [7:0]          s1_abyte_r;

  logic [STAGE_W-1:0]  stage_r,   stage_nxt;
  logic [BUSY_W-1:0]   busy_r,    busy_nxt;
  logic                top_bit_r, top_bit_nxt;
  logic                toggle_r,  toggle_nxt;

  logic                out_valid_r;
  logic [7:0]          o_rdata_r,  o_rdata_nxt;
  logic [CMD_W-1:0]    o_cmd_r,    o_cmd_nxt;
  logic [ADDR_BITS-1:0] o_caddr_r, o_caddr_nxt;
  logic [7:0]          o_cdata_r,  o_cdata_nxt;
  logic                o_busy_r;

  logic                adv;
  logic                in_acc;
  logic                busy;
  seq_out_t            seq;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign busy      = (busy_r != '0);

  nfci_seq_decode u_seq (
    .stage    (stage_r),
    .cmd_addr (s1_addr_r[CA_W-1:0]),
    .wdata    (s1_wdata_r),
    .res      (seq)
  );

  always_comb begin
    stage_nxt   = stage_r;
    busy_nxt    = busy_r;
    top_bit_nxt = top_bit_r;
    toggle_nxt  = toggle_r;
    o_rdata_nxt = '0;
    o_cmd_nxt   = CMD_NONE;
    o_caddr_nxt = '0;
    o_cdata_nxt = '0;
    case (s1_op_r)
      OP_READ: begin
        if (busy) begin
          o_rdata_nxt = {top_bit_r, toggle_r, s1_abyte_r[5:0]};
          toggle_nxt  = !toggle_r;
        end else begin
          o_rdata_nxt = s1_abyte_r;
        end
      end
      OP_WRITE: begin
        if (!busy) begin
          stage_nxt = seq.next_stage;
          o_cmd_nxt = seq.cmd;
          case (seq.cmd)
            CMD_PROGRAM: begin
              busy_nxt    = {{(BUSY_W-16){1'b0}}, prog_ticks_r};
              top_bit_nxt = !s1_wdata_r[7];
              o_caddr_nxt = s1_addr_r;
              o_cdata_nxt = s1_wdata_r;
            end
            CMD_SECTOR_ERASE: begin
              busy_nxt    = sect_ticks_r;
              top_bit_nxt = 1'b0;
              o_caddr_nxt = s1_addr_r;
            end
            CMD_CHIP_ERASE: begin
              busy_nxt    = chip_ticks_r;
              top_bit_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      OP_TICK: begin
        if (busy) busy_nxt = busy_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_ticks_r <= 16'd20;
      sect_ticks_r <= 24'd25000;
      chip_ticks_r <= 24'd100000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PROGRAM_TICKS: prog_ticks_r <= cfg_wdata[15:0];
        REG_SECTOR_TICKS:  sect_ticks_r <= cfg_wdata;
        REG_CHIP_TICKS:    chip_ticks_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_tuser;
      s1_addr_r  <= in_tdata[ADDR_BITS-1:0];
      s1_wdata_r <= in_tdata[ADDR_BITS+7:ADDR_BITS];
      s1_abyte_r <= in_tdata[ADDR_BITS+15:ADDR_BITS+8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_IDLE;
      busy_r      <= '0;
      top_bit_r   <= 1'b0;
      toggle_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        stage_r   <= stage_nxt;
        busy_r    <= busy_nxt;
        top_bit_r <= top_bit_nxt;
        toggle_r  <= toggle_nxt;
      end
      if (adv) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_rdata_r <= o_rdata_nxt;
      o_cmd_r   <= o_cmd_nxt;
      o_caddr_r <= o_caddr_nxt;
      o_cdata_r <= o_cdata_nxt;
      o_busy_r  <= (busy_nxt != '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_cmd_r;
  assign out_tdata  = {{(OUT_W-ADDR_BITS-17){1'b0}}, o_busy_r, o_cdata_r, o_caddr_r, o_rdata_r};

endmodule
`default_nettype wire

// File: tb/tb_nor_flash_command_interface.sv
`timescale 1ns / 1ps

module tb_nor_flash_command_interface;
  import nfci_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE   = 2'd3;
  localparam logic [1:0]      REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0]       read_data;
    logic [CMD_W-1:0] cmd;
    logic [18:0]      cmd_addr;
    logic [7:0]       cmd_data;
    logic             busy;
  } flash_res_t;

  typedef struct {
    bit         is_cfg;
    logic [1:0] sel;
    logic [23:0] val;
    logic [7:0] wd;
    logic [7:0] ab;
    bit         typed;
    flash_res_t res;
  } stim_row_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata   = '0;
  logic [OP_W-1:0]   in_tuser   = OP_READ;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;
  logic [CMD_W-1:0]  out_tuser;
  logic              cfg_wr_en  = 1'b0;
  logic [1:0]        cfg_index  = REG_PROGRAM_TICKS;
  logic [BUSY_W-1:0] cfg_wdata  = '0;

  nor_flash_command_interface u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predicted flash state
  logic [STAGE_W-1:0] trk_stage  = ST_IDLE;
  logic [23:0]        busy_cnt   = '0;
  logic               top_bit    = 1'b0;
  logic               toggle_bit = 1'b0;
  logic [15:0]        dur_prog   = 16'd20;
  logic [23:0]        dur_sec    = 24'd25000;
  logic [23:0]        dur_chip   = 24'd100000;

  flash_res_t pending_responses [$];
  stim_row_t  dir_rows [$];
  int         n_items      = 0;
  int         n_responses  = 0;
  int         mismatches   = 0;
  int         in_idle_pct  = 15;
  int         out_idle_pct = 15;
  flash_res_t got, want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tuser, out_tdata[26:8], out_tdata[34:27], out_tdata[35]};
      n_responses++;
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response %0d with nothing pending: rd=%h cmd=%0d addr=%h data=%h busy=%b",
                   n_responses, got.read_data, got.cmd, got.cmd_addr, got.cmd_data, got.busy);
      end else begin
        want = pending_responses.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"response %0d: exp rd=%h cmd=%0d addr=%h data=%h busy=%b, ",
                      "got rd=%h cmd=%0d addr=%h data=%h busy=%b"}, n_responses,
                     want.read_data, want.cmd, want.cmd_addr, want.cmd_data, want.busy,
                     got.read_data, got.cmd, got.cmd_addr, got.cmd_data, got.busy);
        end
      end
    end
  end

  function automatic flash_res_t flash_response(input logic [OP_W-1:0] op,
                                                input logic [18:0] off,
                                                input logic [7:0] wd, input logic [7:0] ab);
    flash_res_t         r;
    logic [CA_W-1:0]    ca;
    logic               at1, at2;
    logic [STAGE_W-1:0] nxt;
    r   = '0;
    ca  = off[CA_W-1:0];
    at1 = (ca == UNLOCK_ADDR1);
    at2 = (ca == UNLOCK_ADDR2);
    nxt = ST_IDLE;
    case (op)
      OP_READ: begin
        if (busy_cnt != 0) begin
          r.read_data = {top_bit, toggle_bit, ab[5:0]};
          toggle_bit  = ~toggle_bit;
        end else begin
          r.read_data = ab;
        end
      end
      OP_WRITE: begin
        if (busy_cnt == 0) begin
          case (trk_stage)
            ST_IDLE:  if (at1 && wd == DAT_UNLOCK1) nxt = ST_AA1;
            ST_AA1:   if (at2 && wd == DAT_UNLOCK2) nxt = ST_55A;
            ST_55A: begin
              if (at1 && wd == DAT_PROGRAM) nxt = ST_PROG;
              else if (at1 && wd == DAT_ERASE) nxt = ST_ERASE;
            end
            ST_PROG: begin
              r.cmd      = CMD_PROGRAM;
              r.cmd_addr = off;
              r.cmd_data = wd;
              busy_cnt   = {8'd0, dur_prog};
              top_bit    = ~wd[7];
            end
            ST_ERASE: if (at1 && wd == DAT_UNLOCK1) nxt = ST_AA2;
            ST_AA2:   if (at2 && wd == DAT_UNLOCK2) nxt = ST_55B;
            ST_55B: begin
              if (wd == DAT_SECTOR) begin
                r.cmd      = CMD_SECTOR_ERASE;
                r.cmd_addr = off;
                busy_cnt   = dur_sec;
                top_bit    = 1'b0;
              end else if (at1 && wd == DAT_CHIP) begin
                r.cmd    = CMD_CHIP_ERASE;
                busy_cnt = dur_chip;
                top_bit  = 1'b0;
              end
            end
            default: ;
          endcase
          trk_stage = nxt;
        end
      end
      OP_TICK: if (busy_cnt != 0) busy_cnt--;
      default: ;
    endcase
    r.busy = (busy_cnt != 0);
    return r;
  endfunction

  function automatic void add_row(input bit is_cfg, input logic [1:0] sel,
                                  input logic [23:0] val, input logic [7:0] wd,
                                  input logic [7:0] ab, input bit typed, input flash_res_t res);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.sel    = sel;
    row.val    = val;
    row.wd     = wd;
    row.ab     = ab;
    row.typed  = typed;
    row.res    = res;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [18:0] alias_of(input logic [CA_W-1:0] ca);
    logic [3:0] hi;
    hi = 4'($urandom);
    return {hi, ca};
  endfunction

  task automatic send_txn(input logic [OP_W-1:0] op, input logic [18:0] off,
                          input logic [7:0] wd, input logic [7:0] ab);
    cfg_wr_en <= 1'b0;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, ab, wd, off};
    do @(posedge clk); while (!in_tready);
    pending_responses.push_back(flash_response(op, off, wd, ab));
    n_items++;
  endtask

  task automatic send_noise();
    logic [OP_W-1:0] op;
    logic [18:0]     off;
    logic [7:0]      wd, ab;
    op  = OP_W'($urandom_range(3));
    off = 19'($urandom);
    wd  = 8'($urandom);
    ab  = 8'($urandom);
    send_txn(op, off, wd, ab);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_PROGRAM_TICKS: dur_prog = val[15:0];
      REG_SECTOR_TICKS:  dur_sec  = val;
      REG_CHIP_TICKS:    dur_chip = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    cfg_wr_en <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Unlock sequence with random alias bits, optionally corrupted, then up to 40 random reads,
  // ticks and stray writes, until the operation ends and up to three more have been sent.
  task automatic run_sequence();
    logic [18:0] offs [6];
    logic [7:0]  dats [6];
    int          kind, len, bad, extra, guard, r;
    kind    = $urandom_range(2);
    offs[0] = alias_of(UNLOCK_ADDR1);
    dats[0] = DAT_UNLOCK1;
    offs[1] = alias_of(UNLOCK_ADDR2);
    dats[1] = DAT_UNLOCK2;
    offs[2] = alias_of(UNLOCK_ADDR1);
    if (kind == 0) begin
      dats[2] = DAT_PROGRAM;
      offs[3] = 19'($urandom);
      dats[3] = 8'($urandom);
      len     = 4;
    end else begin
      dats[2] = DAT_ERASE;
      offs[3] = alias_of(UNLOCK_ADDR1);
      dats[3] = DAT_UNLOCK1;
      offs[4] = alias_of(UNLOCK_ADDR2);
      dats[4] = DAT_UNLOCK2;
      if (kind == 1) begin
        offs[5] = 19'($urandom);
        dats[5] = DAT_SECTOR;
      end else begin
        offs[5] = alias_of(UNLOCK_ADDR1);
        dats[5] = DAT_CHIP;
      end
      len = 6;
    end
    if ($urandom_range(99) < 20) begin
      bad = $urandom_range(len - 1);
      dats[bad] = 8'($urandom);
      if ($urandom_range(1) == 1) offs[bad] = 19'($urandom);
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 20)
        send_txn($urandom_range(1) ? OP_TICK : OP_READ, 19'($urandom), 8'($urandom),
                 8'($urandom));
      send_txn(OP_WRITE, offs[i], dats[i], 8'($urandom));
    end
    extra = $urandom_range(3);
    guard = 0;
    while ((busy_cnt != 0 || extra > 0) && guard < 40) begin
      guard++;
      if (busy_cnt == 0) extra--;
      r = $urandom_range(99);
      if (r < 50) send_txn(OP_TICK, 19'($urandom), 8'($urandom), 8'($urandom));
      else if (r < 85) send_txn(OP_READ, 19'($urandom), 8'($urandom), 8'($urandom));
      else send_txn(OP_WRITE, 19'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_phase(input logic [23:0] prog, input logic [23:0] sec,
                           input logic [23:0] chip, input int count, input int idle_pct,
                           input bit poke_unused, input bit hold_mid);
    int target, mid;
    bit held;
    wait_drained();
    write_reg(REG_PROGRAM_TICKS, prog);
    write_reg(REG_SECTOR_TICKS, sec);
    write_reg(REG_CHIP_TICKS, chip);
    if (poke_unused) write_reg(REG_UNUSED, 24'hffffff);
    in_idle_pct  = idle_pct;
    out_idle_pct = idle_pct;
    target = n_items + count;
    mid    = n_items + count / 2;
    held   = 1'b0;
    while (n_items < target) begin
      if (hold_mid && !held && n_items >= mid) begin
        wait_drained();
        held = 1'b1;
      end
      if ($urandom_range(99) < 70) run_sequence();
      else send_noise();
    end
  endtask

  initial begin
    bit prev_cfg;

    // idle reads, tick, unused opcode, broken unlock
    add_row(0, OP_READ,  24'h00000, 8'h00, 8'h00, 1, {8'h00, CMD_NONE, 19'h0, 8'h00, 1'b0});
    add_row(0, OP_READ,  24'h7ffff, 8'hff, 8'hff, 1, {8'hff, CMD_NONE, 19'h0, 8'h00, 1'b0});
    add_row(0, OP_TICK,  24'h7ffff, 8'hff, 8'hff, 1, {8'h00, CMD_NONE, 19'h0, 8'h00, 1'b0});
    add_row(0, OP_SPARE, 24'h7ffff, 8'hff, 8'hff, 1, {8'h00, CMD_NONE, 19'h0, 8'h00, 1'b0});
    add_row(0, OP_WRITE, 24'h05555, 8'haa, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h00000, 8'h00, 8'h00, 0, '0);
    // zero durations: erase reported, never busy
    add_row(1, REG_SECTOR_TICKS, 24'd0, 8'h00, 8'h00, 0, '0);
    add_row(1, REG_CHIP_TICKS,   24'd0, 8'h00, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h7d555, 8'haa, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h7aaaa, 8'h55, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h05555, 8'h80, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h05555, 8'haa, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h02aaa, 8'h55, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h61234, 8'h30, 8'h00, 1,
            {8'h00, CMD_SECTOR_ERASE, 19'h61234, 8'h00, 1'b0});
    add_row(0, OP_WRITE, 24'h05555, 8'haa, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h02aaa, 8'h55, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h05555, 8'h80, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h05555, 8'haa, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h02aaa, 8'h55, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h05555, 8'h10, 8'h00, 1, {8'h00, CMD_CHIP_ERASE, 19'h0, 8'h00, 1'b0});
    // program at the reset duration, then status reads and an ignored write
    add_row(0, OP_WRITE, 24'h05555, 8'haa, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h02aaa, 8'h55, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h05555, 8'ha0, 8'h00, 0, '0);
    add_row(0, OP_WRITE, 24'h7ffff, 8'h7f, 8'h00, 1, {8'h00, CMD_PROGRAM, 19'h7ffff, 8'h7f, 1'b1});
    add_row(0, OP_READ,  24'h7ffff, 8'h00, 8'hff, 1, {8'hbf, CMD_NONE, 19'h0, 8'h00, 1'b1});
    add_row(0, OP_READ,  24'h00000, 8'h00, 8'h00, 1, {8'hc0, CMD_NONE, 19'h0, 8'h00, 1'b1});
    add_row(0, OP_WRITE, 24'h05555, 8'haa, 8'h00, 1, {8'h00, CMD_NONE, 19'h0, 8'h00, 1'b1});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_cfg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (!prev_cfg) wait_drained();
        write_reg(dir_rows[i].sel, dir_rows[i].val);
      end else begin
        send_txn(dir_rows[i].sel, dir_rows[i].val[18:0], dir_rows[i].wd, dir_rows[i].ab);
        if (dir_rows[i].typed)
          pending_responses[pending_responses.size() - 1] = dir_rows[i].res;
      end
      prev_cfg = dir_rows[i].is_cfg;
    end

    run_phase(24'd1, 24'd1, 24'd1, 140, 15, 0, 0);
    run_phase(24'd0, 24'd0, 24'd0, 100, 15, 1, 0);
    run_phase(24'd7, 24'd19, 24'd45, 180, 0, 0, 0);
    run_phase(24'd3, 24'd12, 24'd6, 180, 15, 0, 1);
    run_phase(24'hffff, 24'hffffff, 24'hffffff, 100, 15, 0, 0);

    wait_drained();
    mismatches += pending_responses.size();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/nfci_pkg.sv
rtl/core/nfci_seq_decode.sv
rtl/core/nor_flash_command_interface.sv
tb/tb_nor_flash_command_interface.sv
